>>> rtl/core/emgmav_pkg.sv
// ----------------------------------------------------------------------------
// emgmav_pkg
// Shared constants and the command/status bundles between the window
// mean/MAV controller and its datapath.
// ----------------------------------------------------------------------------
package emgmav_pkg;

  // Width of the sample port and of the Q.8 result fields.
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned OUT_W     = 18;
  localparam int unsigned FRAC_BITS = 8;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Controller to datapath.
  typedef struct packed {
    logic accept;      // input beat taken: capture kind and sample
    logic clr_step;    // write zero at the sweep index and advance it
    logic samp_upd;    // replace oldest entry, update sum and counters
    logic walk;        // read the entry at the sweep index and advance it
    logic mav_start;   // clear accumulator and sweep index
    logic div_mean;    // start divider on the scaled window sum
    logic div_mav;     // start divider on the deviation accumulator
    logic mean_latch;  // take the divider quotient as the new mean
    logic out_load;    // load the result registers
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic idx_last;    // sweep index at the last entry
    logic blk_last;    // this sample closes a block
    logic div_busy;    // divider quotient still pending
  } status_t;

endpackage

>>> rtl/core/emg_window_mean_mav.sv
// ----------------------------------------------------------------------------
// emg_window_mean_mav
// Windowed mean and mean absolute value of EMG samples, Q.8 results.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | kind, sample
//  out     | out_valid / out_ready| mean_q, mav_q, mean_updated, mav_valid
//
//  After reset the ring is swept to zero, one entry a cycle; no beat is
//  taken during the sweep.
//  A sample that closes a block also sends the mean through the registered
//  reciprocal-multiply divider.
//  A MAV request reads the ring one entry per cycle for the sweep, drains
//  the deviation pipeline through MAV_DRAIN_A and MAV_DRAIN_B, then runs
//  the divide and the result load.
//  A held result stalls the block only once the next result is ready.
// ----------------------------------------------------------------------------
module emg_window_mean_mav #(
  parameter int unsigned WINDOW_LEN  = 200,
  parameter int unsigned BLOCK_LEN   = 50,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [emgmav_pkg::SAMPLE_W-1:0] sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [emgmav_pkg::OUT_W-1:0]    mean_q,
  output logic [emgmav_pkg::OUT_W-1:0]    mav_q,
  output logic                            mean_updated,
  output logic                            mav_valid
);

  emgmav_pkg::cmd_t    cmd;
  emgmav_pkg::status_t status;

  emgmav_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  emgmav_dp #(
    .WINDOW_LEN  (WINDOW_LEN),
    .BLOCK_LEN   (BLOCK_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (kind),
    .sample       (sample),
    .mean_q       (mean_q),
    .mav_q        (mav_q),
    .mean_updated (mean_updated),
    .mav_valid    (mav_valid)
  );

endmodule

>>> rtl/core/emgmav_div.sv
// ----------------------------------------------------------------------------
// emgmav_div
// Divider by a fixed divisor: registered dividend times a constant
// reciprocal, with the product registered as the quotient.
// ----------------------------------------------------------------------------
module emgmav_div #(
  parameter int unsigned DIV_W   = 26,
  parameter int unsigned DIVISOR = 200
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  // Multiply by ceil(2^SH / DIVISOR); SH leaves enough guard bits for the
  // quotient to be exact over the whole dividend range.
  localparam int unsigned SH = DIV_W + $clog2(DIVISOR);
  localparam int unsigned CW = DIV_W + 2;
  localparam int unsigned PW = SH + DIV_W;
  localparam logic [PW-1:0] RECIP_WIDE =
    ((PW'(1) << SH) + PW'(DIVISOR - 1)) / PW'(DIVISOR);
  localparam logic [CW-1:0] RECIP = RECIP_WIDE[CW-1:0];

  logic [DIV_W-1:0] dvd;
  logic             pend;
  logic [PW-1:0]    prod;

  assign prod = PW'(dvd) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
    if (pend) begin
      quotient <= prod[SH +: DIV_W];
    end
  end

  assign busy = pend;

endmodule

>>> rtl/core/emgmav_dp.sv
// ----------------------------------------------------------------------------
// emgmav_dp
// Sample ring, running window sum, block counter, latched mean, deviation
// accumulator, shared divider and result registers.
// ----------------------------------------------------------------------------
module emgmav_dp #(
  parameter int unsigned WINDOW_LEN  = 200,
  parameter int unsigned BLOCK_LEN   = 50,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  emgmav_pkg::cmd_t                      cmd,
  output emgmav_pkg::status_t                   status,
  input  logic                                  kind,
  input  logic [emgmav_pkg::SAMPLE_W-1:0]       sample,
  output logic [emgmav_pkg::OUT_W-1:0]          mean_q,
  output logic [emgmav_pkg::OUT_W-1:0]          mav_q,
  output logic                                  mean_updated,
  output logic                                  mav_valid
);

  localparam int unsigned XW  = (SAMPLE_BITS < emgmav_pkg::SAMPLE_W) ?
                                SAMPLE_BITS : emgmav_pkg::SAMPLE_W;
  localparam int unsigned AW  = $clog2(WINDOW_LEN);
  localparam int unsigned SW  = XW + AW;
  localparam int unsigned DW  = SW + emgmav_pkg::FRAC_BITS;
  localparam int unsigned BCW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int unsigned OW  = emgmav_pkg::OUT_W;

  logic [XW-1:0]  ring [WINDOW_LEN];
  logic [XW-1:0]  rd_data;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [XW-1:0]  wr_data;

  logic [AW-1:0]  pos;
  logic [AW-1:0]  idx;
  logic [BCW-1:0] blk;
  logic [SW-1:0]  sum;
  logic [SW-1:0]  sum_next;
  logic [OW-1:0]  mean;
  logic [XW-1:0]  x;
  logic           kind_r;
  logic           refresh;

  logic           rd_vld;
  logic           dev_vld;
  logic [OW-1:0]  scaled;
  logic [OW-1:0]  dev;
  logic [DW-1:0]  acc;

  logic           div_start;
  logic [DW-1:0]  div_in;
  logic           div_busy;
  logic [DW-1:0]  quo;
  logic [OW-1:0]  quo_sat;

  logic           pos_last;
  logic           idx_last;
  logic           blk_last;

  assign pos_last = pos == AW'(WINDOW_LEN - 1);
  assign idx_last = idx == AW'(WINDOW_LEN - 1);
  assign blk_last = blk == BCW'(BLOCK_LEN - 1);

  // Ring: one write port, one registered read port.
  assign wr_en   = cmd.clr_step | cmd.samp_upd;
  assign wr_addr = cmd.clr_step ? idx : pos;
  assign wr_data = cmd.clr_step ? '0 : x;
  assign rd_addr = cmd.walk ? idx : pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    rd_data <= ring[rd_addr];
  end

  // rd_data holds the oldest entry here: it was read at the accept edge.
  assign sum_next = sum - SW'(rd_data) + SW'(x);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= kind;
      x      <= sample[XW-1:0];
    end
    if (cmd.samp_upd) begin
      refresh <= blk_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      pos  <= '0;
      idx  <= '0;
      blk  <= '0;
      mean <= '0;
    end else begin
      if (cmd.samp_upd) begin
        sum <= sum_next;
        pos <= pos_last ? '0 : pos + 1'b1;
        blk <= blk_last ? '0 : blk + 1'b1;
      end
      if (cmd.mav_start) begin
        idx <= '0;
      end else if (cmd.clr_step || cmd.walk) begin
        idx <= idx_last ? '0 : idx + 1'b1;
      end
      if (cmd.mean_latch) begin
        mean <= quo_sat;
      end
    end
  end

  // Deviation pipeline: read, absolute difference, accumulate.
  assign scaled = OW'(rd_data) << emgmav_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      dev_vld <= 1'b0;
    end else begin
      rd_vld  <= cmd.walk;
      dev_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    dev <= (scaled >= mean) ? scaled - mean : mean - scaled;
    if (cmd.mav_start) begin
      acc <= '0;
    end else if (dev_vld) begin
      acc <= acc + DW'(dev);
    end
  end

  assign div_start = cmd.div_mean | cmd.div_mav;
  assign div_in    = cmd.div_mean ? {sum_next, {emgmav_pkg::FRAC_BITS{1'b0}}} : acc;

  emgmav_div #(
    .DIV_W   (DW),
    .DIVISOR (WINDOW_LEN)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign quo_sat = (quo > DW'(emgmav_pkg::OUT_MAX)) ? emgmav_pkg::OUT_MAX : quo[OW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_q       <= mean;
      mav_q        <= kind_r ? quo_sat : '0;
      mean_updated <= ~kind_r & refresh;
      mav_valid    <= kind_r;
    end
  end

  assign status.idx_last = idx_last;
  assign status.blk_last = blk_last;
  assign status.div_busy = div_busy;

endmodule

>>> rtl/core/emgmav_ctrl.sv
// ----------------------------------------------------------------------------
// emgmav_ctrl
// Sequencer: post-reset ring clear, sample update, MAV sweep, divide and
// result handoff.
// ----------------------------------------------------------------------------
module emgmav_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  output logic                out_valid,
  input  logic                out_ready,
  output emgmav_pkg::cmd_t    cmd,
  input  emgmav_pkg::status_t status
);

  typedef enum logic [3:0] {
    CLEAR,
    IDLE,
    SAMP_UPD,
    MEAN_DIV,
    MAV_WALK,
    MAV_DRAIN_A,
    MAV_DRAIN_B,
    MAV_DIV_START,
    MAV_DIV,
    RESULT
  } state_t;

  state_t state;
  logic   accept;
  logic   slot_free;

  assign in_ready  = state == IDLE;
  assign accept    = in_valid & in_ready;
  assign slot_free = ~out_valid | out_ready;

  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.mav_start  = accept & kind;
    cmd.clr_step   = state == CLEAR;
    cmd.samp_upd   = state == SAMP_UPD;
    cmd.div_mean   = (state == SAMP_UPD) & status.blk_last;
    cmd.walk       = state == MAV_WALK;
    cmd.div_mav    = state == MAV_DIV_START;
    cmd.mean_latch = (state == MEAN_DIV) & ~status.div_busy;
    cmd.out_load   = (state == RESULT) & slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          if (status.idx_last) state <= IDLE;
        end
        IDLE: begin
          if (accept) state <= kind ? MAV_WALK : SAMP_UPD;
        end
        SAMP_UPD: begin
          state <= status.blk_last ? MEAN_DIV : RESULT;
        end
        MEAN_DIV: begin
          if (!status.div_busy) state <= RESULT;
        end
        MAV_WALK: begin
          if (status.idx_last) state <= MAV_DRAIN_A;
        end
        MAV_DRAIN_A: begin
          state <= MAV_DRAIN_B;
        end
        MAV_DRAIN_B: begin
          state <= MAV_DIV_START;
        end
        MAV_DIV_START: begin
          state <= MAV_DIV;
        end
        MAV_DIV: begin
          if (!status.div_busy) state <= RESULT;
        end
        RESULT: begin
          if (slot_free) state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_emg_window_mean_mav.sv
// ----------------------------------------------------------------------------
// tb_emg_window_mean_mav
// Self-checking bench for the windowed mean / MAV block. A scoreboard keeps
// its own copy of the sample ring, running sum and latched mean, predicts
// one result beat per accepted input beat, and checks every output beat in
// order. Directed beats cover reset state and sample extremes. Random
// segments of samples (uniform, saturated, zero, alternating, near a level)
// are mixed with MAV requests under four idle/stall phases.
// ----------------------------------------------------------------------------
module tb_emg_window_mean_mav;

  localparam int unsigned WINDOW_LEN   = 200;
  localparam int unsigned BLOCK_LEN    = 50;
  localparam int unsigned SAMPLE_BITS  = 10;
  localparam int unsigned PHASE_ITEMS  = 400;
  localparam int unsigned MAV_PCT      = 12;
  localparam int unsigned DRAIN_CYCLES = 300;

  localparam int unsigned      SAMPLE_W  = emgmav_pkg::SAMPLE_W;
  localparam int unsigned      OUT_W     = emgmav_pkg::OUT_W;
  localparam int unsigned      FRAC_BITS = emgmav_pkg::FRAC_BITS;
  localparam logic [OUT_W-1:0] OUT_MAX   = emgmav_pkg::OUT_MAX;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_MAV    = 1'b1
  } item_kind_t;

  typedef enum int unsigned {
    SEG_UNIFORM,
    SEG_FULL,
    SEG_ZERO,
    SEG_ALTERNATE,
    SEG_NEAR_LEVEL
  } seg_kind_t;

  typedef struct {
    bit [OUT_W-1:0] mean_q;
    bit [OUT_W-1:0] mav_q;
    bit             mean_updated;
    bit             mav_valid;
  } stats_t;

  class stats_board_t;
    bit [SAMPLE_W-1:0] ring [WINDOW_LEN];
    bit [OUT_W-1:0]    window_sum;
    int unsigned       wr_pos;
    int unsigned       blk_cnt;
    bit [OUT_W-1:0]    mean_reg;
    stats_t            expected_stats [$];
    int                errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      window_sum = '0;
      wr_pos     = 0;
      blk_cnt    = 0;
      mean_reg   = '0;
      errors     = 0;
    endfunction

    function bit [OUT_W-1:0] saturate(longint unsigned v);
      return (v > OUT_MAX) ? OUT_MAX : v[OUT_W-1:0];
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int unsigned pending();
      return expected_stats.size();
    endfunction

    // Advance the predicted state by one accepted input beat.
    function void take_item(item_kind_t k, bit [SAMPLE_W-1:0] s);
      stats_t          e;
      longint unsigned acc;
      longint unsigned v;
      e.mean_updated = 1'b0;
      e.mav_valid    = 1'b0;
      e.mav_q        = '0;
      if (k == KIND_SAMPLE) begin
        window_sum = window_sum - ring[wr_pos] + s;
        ring[wr_pos] = s;
        wr_pos = (wr_pos + 1 >= WINDOW_LEN) ? 0 : wr_pos + 1;
        blk_cnt++;
        if (blk_cnt >= BLOCK_LEN) begin
          blk_cnt = 0;
          mean_reg = saturate((longint'(window_sum) << FRAC_BITS) / WINDOW_LEN);
          e.mean_updated = 1'b1;
        end
      end else begin
        acc = 0;
        foreach (ring[i]) begin
          v = longint'(ring[i]) << FRAC_BITS;
          acc += (v >= mean_reg) ? v - mean_reg : mean_reg - v;
        end
        e.mav_q     = saturate(acc / WINDOW_LEN);
        e.mav_valid = 1'b1;
      end
      e.mean_q = mean_reg;
      expected_stats.push_back(e);
    endfunction

    task check_stats(bit [OUT_W-1:0] mean_q, bit [OUT_W-1:0] mav_q,
                     bit mean_updated, bit mav_valid);
      stats_t e;
      if (expected_stats.size() == 0) begin
        report($sformatf("result beat with nothing expected (mean_q=%0d mav_q=%0d)",
                         mean_q, mav_q));
        return;
      end
      e = expected_stats.pop_front();
      if (mean_q != e.mean_q)
        report($sformatf("mean_q got %0d expected %0d", mean_q, e.mean_q));
      if (mav_q != e.mav_q)
        report($sformatf("mav_q got %0d expected %0d", mav_q, e.mav_q));
      if (mean_updated != e.mean_updated)
        report($sformatf("mean_updated got %0b expected %0b", mean_updated,
                         e.mean_updated));
      if (mav_valid != e.mav_valid)
        report($sformatf("mav_valid got %0b expected %0b", mav_valid, e.mav_valid));
    endtask
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic                kind      = KIND_SAMPLE;
  logic [SAMPLE_W-1:0] sample    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OUT_W-1:0]    mean_q;
  logic [OUT_W-1:0]    mav_q;
  logic                mean_updated;
  logic                mav_valid;

  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  stats_board_t  board;

  emg_window_mean_mav #(
    .WINDOW_LEN (WINDOW_LEN),
    .BLOCK_LEN  (BLOCK_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mean_q      (mean_q),
    .mav_q       (mav_q),
    .mean_updated(mean_updated),
    .mav_valid   (mav_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_stats(mean_q, mav_q, mean_updated, mav_valid);
  end

  // Drive one input beat; entered and left at a falling edge.
  task automatic send_item(input item_kind_t k, input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_item(k, s);
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(seg_kind_t seg, int unsigned idx,
                                                      int unsigned level);
    int t;
    case (seg)
      SEG_FULL:      return '1;
      SEG_ZERO:      return '0;
      SEG_ALTERNATE: return idx[0] ? '1 : '0;
      SEG_NEAR_LEVEL: begin
        t = int'(level) + int'($urandom_range(16)) - 8;
        if (t < 0) t = 0;
        if (t > 1023) t = 1023;
        return t[SAMPLE_W-1:0];
      end
      default:       return SAMPLE_W'($urandom_range(1023));
    endcase
  endfunction

  initial begin
    seg_kind_t   seg;
    int unsigned seg_len;
    int unsigned level;
    int unsigned sent;
    board = new();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Request on the cleared ring, sample field set but ignored.
    send_item(KIND_MAV, 10'd1023);
    send_item(KIND_SAMPLE, 10'd1023);
    send_item(KIND_SAMPLE, 10'd0);
    send_item(KIND_SAMPLE, 10'd1023);
    // No mean latched yet: plain average of the ring.
    send_item(KIND_MAV, 10'd0);
    send_item(KIND_SAMPLE, 10'd512);
    send_item(KIND_SAMPLE, 10'd1);
    send_item(KIND_SAMPLE, 10'd1022);
    send_item(KIND_SAMPLE, 10'd341);
    send_item(KIND_SAMPLE, 10'd682);
    send_item(KIND_MAV, 10'd682);
    send_item(KIND_MAV, 10'd341);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        seg     = seg_kind_t'($urandom_range(4));
        seg_len = $urandom_range(10, 260);
        level   = $urandom_range(1023);
        for (int j = 0; j < seg_len && sent < PHASE_ITEMS; j++) begin
          if ($urandom_range(99) < MAV_PCT)
            send_item(KIND_MAV, SAMPLE_W'($urandom_range(1023)));
          else
            send_item(KIND_SAMPLE, pick_sample(seg, j, level));
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("tb_emg_window_mean_mav OK");
    else
      $display("tb_emg_window_mean_mav NOT OK");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb_emg_window_mean_mav NOT OK");
    $finish;
  end

endmodule

>>> files.f
rtl/core/emgmav_pkg.sv
rtl/core/emgmav_div.sv
rtl/core/emgmav_dp.sv
rtl/core/emgmav_ctrl.sv
rtl/core/emg_window_mean_mav.sv
tb/tb_emg_window_mean_mav.sv
